// ===== src/rrrt_pkg.sv =====
// Shared types and constants for the route request retry table.
`default_nettype none
package rrrt_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;

  localparam int ADDR_W      = 32;
  localparam int TIME_W      = 32;
  localparam int TO_W        = 16;
  localparam int ATT_W       = 8;
  localparam int SLOT_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_TO = 2'd0,
    CFG_MAX_TO  = 2'd1,
    CFG_MAX_ATT = 2'd2
  } cfg_idx_t;

  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam logic EV_SEND   = 1'b0;
  localparam logic EV_DROP   = 1'b1;

  localparam logic [TO_W-1:0]  RST_INIT_TO = 16'd50;
  localparam logic [TO_W-1:0]  RST_MAX_TO  = 16'd1000;
  localparam logic [ATT_W-1:0] RST_MAX_ATT = 8'd8;

  typedef struct packed {
    logic [ATT_W-1:0]  att;
    logic [TO_W-1:0]   rem;
    logic [TO_W-1:0]   intv;
    logic [TIME_W-1:0] start;
    logic [ADDR_W-1:0] target;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic ev_stall;
    logic fin_stall;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/rrrt_ram.sv =====
// Generic single write port RAM with registered read.
`default_nettype none
module rrrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/rrrt_ctrl.sv =====
// Sequencer: accepts an item, walks the table one entry a cycle unless stalled, then finishes.
`default_nettype none
module rrrt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire rrrt_pkg::sts_t sts,
  output rrrt_pkg::cmd_t     cmd
);
  import rrrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.ev_stall) begin
          cmd.step = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!sts.fin_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/rrrt_dp.sv =====
// Datapath: entry RAM, valid bits, scan registers, result pending/output stages.
`default_nettype none
module rrrt_dp #(
  parameter int TABLE_ENTRIES = rrrt_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire rrrt_pkg::cmd_t                       cmd,
  output rrrt_pkg::sts_t                            sts,
  input  wire logic [rrrt_pkg::ADDR_W-1:0]          in_tdata,
  input  wire logic                                 in_tuser,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [rrrt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rrrt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [rrrt_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic                                      out_tuser,
  output logic                                      out_tlast
);
  import rrrt_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int OW = $clog2(TABLE_ENTRIES + 1);
  localparam int PAD_W = OUT_TDATA_W - ADDR_W - SLOT_W - ATT_W;

  // control state
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [OW-1:0]            occ_r, occ_nxt;
  logic [TIME_W-1:0]        tick_r, tick_nxt;
  logic [TO_W-1:0]          init_to_r, init_to_nxt;
  logic [TO_W-1:0]          max_to_r, max_to_nxt;
  logic [ATT_W-1:0]         max_att_r, max_att_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     pend_v_r, pend_v_nxt;

  // payload
  logic                     kind_r, kind_nxt;
  logic [ADDR_W-1:0]        addr_r, addr_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic                     dup_r, dup_nxt;
  logic [IW-1:0]            oldest_r, oldest_nxt;
  logic [TIME_W-1:0]        oldest_start_r, oldest_start_nxt;
  logic [IW-1:0]            empty_r, empty_nxt;
  logic                     pend_ev_r, pend_ev_nxt;
  logic [ADDR_W-1:0]        pend_addr_r, pend_addr_nxt;
  logic [SLOT_W-1:0]        pend_slot_r, pend_slot_nxt;
  logic [ATT_W-1:0]         pend_att_r, pend_att_nxt;
  logic                     out_ev_r, out_ev_nxt;
  logic [ADDR_W-1:0]        out_addr_r, out_addr_nxt;
  logic [SLOT_W-1:0]        out_slot_r, out_slot_nxt;
  logic [ATT_W-1:0]         out_att_r, out_att_nxt;
  logic                     out_last_r, out_last_nxt;

  // entry RAM
  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_e, wr_e;

  rrrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_e),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_e = entry_t'(ram_rdata);

  logic              cur_v, expire, retry, full, out_free, need_result;
  logic [TO_W:0]     dbl;
  logic [TO_W-1:0]   new_int;
  logic [ATT_W-1:0]  att_inc;
  logic [IW-1:0]     pick;

  always_comb begin
    cur_v       = valid_r[idx_r];
    expire      = rd_e.rem < TO_W'(2);
    retry       = rd_e.att < max_att_r;
    dbl         = {rd_e.intv, 1'b0};
    new_int     = (dbl < {1'b0, max_to_r}) ? dbl[TO_W-1:0] : max_to_r;
    att_inc     = rd_e.att + ATT_W'(1);
    full        = occ_r == OW'(TABLE_ENTRIES);
    pick        = full ? oldest_r : empty_r;
    out_free    = !out_valid_r || out_tready;
    need_result = (kind_r == KIND_TICK) && cur_v && expire;
  end

  always_comb begin
    sts.idx_last  = idx_r == IW'(TABLE_ENTRIES - 1);
    // a second expiry must wait until the held result can move to the output
    sts.ev_stall  = need_result && pend_v_r && !out_free;
    sts.fin_stall = (((kind_r == KIND_REQ) && !dup_r) ||
                     ((kind_r == KIND_TICK) && pend_v_r)) && !out_free;
  end

  // read address runs one entry ahead of the step so data is ready next cycle
  always_comb begin
    if (cmd.accept) begin
      ram_raddr = '0;
    end else if (cmd.step) begin
      ram_raddr = idx_r + IW'(1);
    end else begin
      ram_raddr = idx_r;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    wr_e      = rd_e;
    if (cmd.step && (kind_r == KIND_TICK) && cur_v) begin
      if (!expire) begin
        ram_we     = 1'b1;
        wr_e.rem   = rd_e.rem - TO_W'(1);
      end else if (retry) begin
        ram_we     = 1'b1;
        wr_e.att   = att_inc;
        wr_e.intv  = new_int;
        wr_e.rem   = new_int;
      end
    end else if (cmd.finish && (kind_r == KIND_REQ) && !dup_r) begin
      ram_we      = 1'b1;
      ram_waddr   = pick;
      wr_e.att    = ATT_W'(1);
      wr_e.rem    = init_to_r;
      wr_e.intv   = init_to_r;
      wr_e.start  = tick_r;
      wr_e.target = addr_r;
    end
  end

  always_comb begin
    valid_nxt        = valid_r;
    occ_nxt          = occ_r;
    tick_nxt         = tick_r;
    init_to_nxt      = init_to_r;
    max_to_nxt       = max_to_r;
    max_att_nxt      = max_att_r;
    out_valid_nxt    = out_valid_r;
    pend_v_nxt       = pend_v_r;
    kind_nxt         = kind_r;
    addr_nxt         = addr_r;
    idx_nxt          = idx_r;
    dup_nxt          = dup_r;
    oldest_nxt       = oldest_r;
    oldest_start_nxt = oldest_start_r;
    empty_nxt        = empty_r;
    pend_ev_nxt      = pend_ev_r;
    pend_addr_nxt    = pend_addr_r;
    pend_slot_nxt    = pend_slot_r;
    pend_att_nxt     = pend_att_r;
    out_ev_nxt       = out_ev_r;
    out_addr_nxt     = out_addr_r;
    out_slot_nxt     = out_slot_r;
    out_att_nxt      = out_att_r;
    out_last_nxt     = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INIT_TO: init_to_nxt = cfg_wdata;
        CFG_MAX_TO:  max_to_nxt  = cfg_wdata;
        CFG_MAX_ATT: max_att_nxt = cfg_wdata[ATT_W-1:0];
        default: ;
      endcase
    end

    if (cmd.accept) begin
      kind_nxt   = in_tuser;
      addr_nxt   = in_tdata;
      idx_nxt    = '0;
      dup_nxt    = 1'b0;
      pend_v_nxt = 1'b0;
      if (in_tuser == KIND_TICK) begin
        tick_nxt = tick_r + TIME_W'(1);
      end
    end

    if (cmd.step) begin
      idx_nxt = idx_r + IW'(1);
      if (kind_r == KIND_REQ) begin
        if (cur_v && (rd_e.target == addr_r)) begin
          dup_nxt = 1'b1;
        end
        if (idx_r == '0) begin
          oldest_nxt       = '0;
          oldest_start_nxt = rd_e.start;
        end else if (cur_v && (rd_e.start < oldest_start_r)) begin
          oldest_nxt       = idx_r;
          oldest_start_nxt = rd_e.start;
        end
        if (!cur_v) begin
          empty_nxt = idx_r;
        end
      end else if (need_result) begin
        // hold the newest result back so the final one can carry last
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = pend_ev_r;
          out_addr_nxt  = pend_addr_r;
          out_slot_nxt  = pend_slot_r;
          out_att_nxt   = pend_att_r;
          out_last_nxt  = 1'b0;
        end
        pend_v_nxt    = 1'b1;
        pend_addr_nxt = rd_e.target;
        pend_slot_nxt = SLOT_W'(idx_r);
        if (retry) begin
          pend_ev_nxt  = EV_SEND;
          pend_att_nxt = att_inc;
        end else begin
          pend_ev_nxt        = EV_DROP;
          pend_att_nxt       = rd_e.att;
          valid_nxt[idx_r]   = 1'b0;
          occ_nxt            = occ_r - OW'(1);
        end
      end
    end

    if (cmd.finish) begin
      if ((kind_r == KIND_REQ) && !dup_r) begin
        valid_nxt[pick] = 1'b1;
        if (!full) begin
          occ_nxt = occ_r + OW'(1);
        end
        out_valid_nxt = 1'b1;
        out_ev_nxt    = EV_SEND;
        out_addr_nxt  = addr_r;
        out_slot_nxt  = SLOT_W'(pick);
        out_att_nxt   = ATT_W'(1);
        out_last_nxt  = 1'b1;
      end else if ((kind_r == KIND_TICK) && pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_ev_nxt    = pend_ev_r;
        out_addr_nxt  = pend_addr_r;
        out_slot_nxt  = pend_slot_r;
        out_att_nxt   = pend_att_r;
        out_last_nxt  = 1'b1;
        pend_v_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      occ_r       <= '0;
      tick_r      <= '0;
      init_to_r   <= RST_INIT_TO;
      max_to_r    <= RST_MAX_TO;
      max_att_r   <= RST_MAX_ATT;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      occ_r       <= occ_nxt;
      tick_r      <= tick_nxt;
      init_to_r   <= init_to_nxt;
      max_to_r    <= max_to_nxt;
      max_att_r   <= max_att_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r         <= kind_nxt;
    addr_r         <= addr_nxt;
    idx_r          <= idx_nxt;
    dup_r          <= dup_nxt;
    oldest_r       <= oldest_nxt;
    oldest_start_r <= oldest_start_nxt;
    empty_r        <= empty_nxt;
    pend_ev_r      <= pend_ev_nxt;
    pend_addr_r    <= pend_addr_nxt;
    pend_slot_r    <= pend_slot_nxt;
    pend_att_r     <= pend_att_nxt;
    out_ev_r       <= out_ev_nxt;
    out_addr_r     <= out_addr_nxt;
    out_slot_r     <= out_slot_nxt;
    out_att_r      <= out_att_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {PAD_W'(0), out_att_r, out_slot_r, out_addr_r};
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== src/route_request_retry_table.sv =====
// Top level of the route request retry table.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------------
//  in      | in  | in_tvalid/in_tready | tuser: kind; tdata: target_addr
//  out     | out | out_tvalid/tready   | tuser: event_res; tdata: addr,slot,attempt;
//          |     |                     | tlast: last
//  cfg     | in  | cfg_wr_en           | cfg_index, cfg_wdata
//
// Each item passes accept, a walk over every entry through the entry RAM's single
// read port, and a finish; a new item is taken only after the finish.
// Reset (synchronous, rst_n low) clears valid bits, occupancy, tick count and
// restores register defaults; entry RAM contents are not cleared.
// A full output register stalls the walk only when a further result is due.
`default_nettype none
module route_request_retry_table #(
  parameter int TABLE_ENTRIES = rrrt_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [rrrt_pkg::ADDR_W-1:0]          in_tdata,   // [31:0] target_addr
  input  wire logic                                 in_tuser,   // [0] kind
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [rrrt_pkg::OUT_TDATA_W-1:0]          out_tdata,  // [31:0] addr, [35:32] slot,
                                                                // [43:36] attempt
  output logic                                      out_tuser,  // [0] event_res
  output logic                                      out_tlast,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [rrrt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rrrt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import rrrt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rrrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrrt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== sim/route_event_checker.sv =====
// Checker that predicts route request table events and compares them with the out channel.
`timescale 1ns / 1ps
module route_event_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  input  wire logic                              in_tready,
  input  wire logic [rrrt_pkg::ADDR_W-1:0]       in_tdata,   // [31:0] target_addr
  input  wire logic                              in_tuser,   // [0] kind
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic [rrrt_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [31:0] addr, [35:32] slot,
                                                             // [43:36] attempt
  input  wire logic                              out_tuser,  // [0] event_res
  input  wire logic                              out_tlast,
  input  wire logic                              cfg_wr_en,
  input  wire logic [rrrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rrrt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                     mismatch_count,
  output int                                     open_events
);
  import rrrt_pkg::*;

  localparam int N = DEF_TABLE_ENTRIES;

  typedef struct packed {
    logic              drop;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] slot;
    logic [ATT_W-1:0]  att;
    logic              last;
  } route_event_t;

  logic              ent_valid  [N];
  logic [ADDR_W-1:0] ent_target [N];
  logic [TIME_W-1:0] ent_start  [N];
  logic [TO_W-1:0]   ent_intv   [N];
  logic [TO_W-1:0]   ent_rem    [N];
  logic [ATT_W-1:0]  ent_att    [N];
  int                occupied;
  logic [TIME_W-1:0] tick_count;
  logic [TO_W-1:0]   first_to;
  logic [TO_W-1:0]   ceil_to;
  logic [ATT_W-1:0]  att_limit;

  route_event_t due_events[$];

  function automatic void check_field(string what, logic [ADDR_W-1:0] want,
                                      logic [ADDR_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endfunction

  // New target: highest free slot, else the oldest start time (lowest index on a tie).
  task automatic arm_route_request(input logic [ADDR_W-1:0] addr);
    int           pick;
    int           oldest;
    logic         dup;
    route_event_t ev;
    pick   = -1;
    oldest = -1;
    dup    = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (ent_valid[i]) begin
        if (ent_target[i] == addr) dup = 1'b1;
        if (oldest < 0 || ent_start[i] < ent_start[oldest]) oldest = i;
      end else begin
        pick = i;
      end
    end
    if (!dup) begin
      if (pick < 0) begin
        pick = oldest;
      end else begin
        occupied++;
      end
      ent_valid[pick]  = 1'b1;
      ent_target[pick] = addr;
      ent_start[pick]  = tick_count;
      ent_intv[pick]   = first_to;
      ent_rem[pick]    = first_to;
      ent_att[pick]    = 8'd1;
      ev = '{EV_SEND, addr, SLOT_W'(pick), 8'd1, 1'b1};
      due_events.push_back(ev);
    end
  endtask

  task automatic advance_tick();
    route_event_t  burst [N];
    route_event_t  ev;
    int            n;
    logic [TO_W:0] dbl;
    n = 0;
    tick_count = tick_count + 1;
    for (int i = 0; i < N; i++) begin
      if (ent_valid[i]) begin
        if (ent_rem[i] > 1) begin
          ent_rem[i] = ent_rem[i] - 1;
        end else if (ent_att[i] < att_limit) begin
          dbl         = {ent_intv[i], 1'b0};
          ent_att[i]  = ent_att[i] + 1;
          ent_intv[i] = (dbl < {1'b0, ceil_to}) ? dbl[TO_W-1:0] : ceil_to;
          ent_rem[i]  = ent_intv[i];
          burst[n] = '{EV_SEND, ent_target[i], SLOT_W'(i), ent_att[i], 1'b0};
          n++;
        end else begin
          ent_valid[i] = 1'b0;
          if (occupied > 0) occupied--;
          burst[n] = '{EV_DROP, ent_target[i], SLOT_W'(i), ent_att[i], 1'b0};
          n++;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      ev      = burst[k];
      ev.last = (k == n - 1);
      due_events.push_back(ev);
    end
  endtask

  always @(posedge clk) begin : watch
    route_event_t seen;
    route_event_t want;
    if (!rst_n) begin
      for (int i = 0; i < N; i++) ent_valid[i] = 1'b0;
      occupied   = 0;
      tick_count = '0;
      first_to   = RST_INIT_TO;
      ceil_to    = RST_MAX_TO;
      att_limit  = RST_MAX_ATT;
    end else begin
      // results first: a result accepted here never belongs to an item taken at this edge
      if (out_tvalid && out_tready) begin
        seen = '{out_tuser, out_tdata[ADDR_W-1:0], out_tdata[ADDR_W+SLOT_W-1:ADDR_W],
                 out_tdata[ADDR_W+SLOT_W+ATT_W-1:ADDR_W+SLOT_W], out_tlast};
        if (due_events.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got %h", $time, seen);
        end else begin
          want = due_events.pop_front();
          check_field("event_res", want.drop, seen.drop);
          check_field("addr", want.addr, seen.addr);
          check_field("slot", want.slot, seen.slot);
          check_field("attempt", want.att, seen.att);
          check_field("last", want.last, seen.last);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_INIT_TO: first_to  = cfg_wdata;
          CFG_MAX_TO:  ceil_to   = cfg_wdata;
          CFG_MAX_ATT: att_limit = cfg_wdata[ATT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_TICK) begin
          advance_tick();
        end else begin
          arm_route_request(in_tdata);
        end
      end
    end
    open_events = due_events.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Testbench top: drives requests, ticks and register writes, and reports the verdict.
`timescale 1ns / 1ps
module testbench;
  import rrrt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int POOL_SIZE     = 20;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 50;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic [ADDR_W-1:0]       in_tdata   = '0;
  logic                    in_tuser   = KIND_REQ;
  logic                    out_tready = 1'b0;
  logic                    cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = CFG_INIT_TO;
  logic [CFG_DATA_W-1:0]   cfg_wdata  = '0;
  logic                    calm       = 1'b0;
  wire logic               in_tready;
  wire logic               out_tvalid;
  wire logic [OUT_TDATA_W-1:0] out_tdata;
  wire logic               out_tuser;
  wire logic               out_tlast;
  int                      mismatch_count;
  int                      open_events;
  logic [ADDR_W-1:0]       addr_pool [POOL_SIZE];

  route_request_retry_table dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  route_event_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_wr_en, .cfg_index, .cfg_wdata,
    .mismatch_count, .open_events
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 6);
  end

  task automatic send_item(input logic kind, input logic [ADDR_W-1:0] addr);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold off until every result is in, then let any silent item finish its walk.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_events != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Junk goes in the upper byte of max_attempts and to the spare index.
  task automatic set_timing(input logic [TO_W-1:0] init_to, input logic [TO_W-1:0] max_to,
                            input logic [ATT_W-1:0] att);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_INIT_TO;
    cfg_wdata <= init_to;
    @(posedge clk);
    cfg_index <= CFG_MAX_TO;
    cfg_wdata <= max_to;
    @(posedge clk);
    cfg_index <= CFG_MAX_ATT;
    cfg_wdata <= {8'($urandom_range(0, 255)), att};
    @(posedge clk);
    cfg_index <= CFG_IDX_SPARE;
    cfg_wdata <= 16'($urandom_range(0, 65535));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_item();
    logic [ADDR_W-1:0] a;
    a = $urandom();
    if ($urandom_range(0, 99) < 55) begin
      send_item(KIND_TICK, a);
    end else begin
      // mostly a small pool so duplicates and a full table come up often
      if ($urandom_range(0, 3) != 0) a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_item(KIND_REQ, a);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero address, all-ones address, duplicate, quiet tick
    send_item(KIND_REQ, 32'h0000_0000);
    send_item(KIND_REQ, 32'hFFFF_FFFF);
    send_item(KIND_REQ, 32'h0000_0000);
    send_item(KIND_TICK, 32'hFFFF_FFFF);

    // short timer: one retry, a quiet tick, then give up
    settle();
    set_timing(16'd1, 16'd3, 8'd2);
    send_item(KIND_REQ, 32'hA5A5_A5A5);
    send_item(KIND_TICK, 32'h0000_0000);
    send_item(KIND_TICK, 32'h5555_5555);
    send_item(KIND_TICK, 32'hAAAA_AAAA);

    // zero interval and zero attempt limit: dropped on the first tick
    settle();
    set_timing(16'd0, 16'd0, 8'd0);
    send_item(KIND_REQ, 32'h5A5A_5A5A);
    send_item(KIND_TICK, 32'h0000_0000);

    // fill the table, then replace the oldest entry
    settle();
    set_timing(16'hFFFF, 16'hFFFF, 8'd255);
    for (int k = 0; k < 15; k++) send_item(KIND_REQ, 32'h8000_0000 + k * 32'h0101_0101);
    send_item(KIND_TICK, 32'h0F0F_0F0F);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: set_timing(16'd1, 16'd4, 8'd3);
        1: set_timing(16'd0, 16'd0, 8'd255);
        2: set_timing(16'd2, 16'hFFFF, 8'd255);
        3: set_timing(16'hFFFF, 16'hFFFF, 8'd1);
        4: set_timing(16'd3, 16'd1, 8'd5);
        5: set_timing(16'd0, 16'd0, 8'd0);
        default: set_timing(16'($urandom_range(0, 5)), 16'($urandom_range(0, 12)),
                            8'($urandom_range(0, 4)));
      endcase
      calm <= (ph == 2);
      for (int k = 0; k < POOL_SIZE; k++) addr_pool[k] = $urandom();
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    if (mismatch_count == 0 && open_events == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rrrt_pkg.sv
src/rrrt_ram.sv
src/rrrt_ctrl.sv
src/rrrt_dp.sv
src/route_request_retry_table.sv
sim/route_event_checker.sv
sim/testbench.sv
